### design/pss_pkg.sv
// Shared types, constants and signature strings for the payload signature scanner.
package pss_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;

    localparam int unsigned HIST_DEPTH = 11;
    localparam int unsigned WIN_BITS   = (HIST_DEPTH + 1) * 8;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_C = 2'd2;

    localparam logic [15:0] PORT_A_RST = 16'd4444;
    localparam logic [15:0] PORT_B_RST = 16'd31337;
    localparam logic [15:0] PORT_C_RST = 16'd1337;

    localparam logic [7:0] HIGH_LIMIT = 8'd127;
    localparam logic [6:0] SCORE_CAP  = 7'd100;

    // Signatures, first character in the top byte
    localparam logic [23:0] PAT_SLED = 24'h909090;
    localparam logic [87:0] PAT_SQL0 = "' OR '1'='1";
    localparam logic [95:0] PAT_SQL1 = "UNION SELECT";
    localparam logic [79:0] PAT_SQL2 = "DROP TABLE";
    localparam logic [63:0] PAT_JS0  = "<script>";
    localparam logic [87:0] PAT_JS1  = "javascript:";

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        last_byte;
        logic [15:0] dst_port;
        logic        files_changed;
    } t_in_item;

    typedef struct packed {
        logic       injection_seen;
        logic       net_flag;
        logic       suspicious_calls;
        logic [2:0] tag_count;
        logic [6:0] risk_score;
    } t_out_item;

    typedef struct packed {
        logic sled;
        logic sql;
        logic script;
    } t_match_flags;

    typedef struct packed {
        t_match_flags flags;
        logic         encoded;
        logic         net;
        logic         files;
    } t_score_in;

endpackage

### design/pss_match.sv
// Tail matcher: checks the newest bytes of the window against each signature.
module pss_match
    import pss_pkg::*;
(
    input  logic [WIN_BITS-1:0] i_window,
    output t_match_flags        o_flags
);

    // Current byte sits in the low byte; unfilled history is zero and matches nothing.
    always_comb begin
        o_flags.sled   = (i_window[23:0] == PAT_SLED);
        o_flags.sql    = (i_window[87:0] == PAT_SQL0) ||
                         (i_window[95:0] == PAT_SQL1) ||
                         (i_window[79:0] == PAT_SQL2);
        o_flags.script = (i_window[63:0] == PAT_JS0) ||
                         (i_window[87:0] == PAT_JS1);
    end

endmodule

### design/pss_score.sv
// Result builder: tag count and weighted threat score from the packet flags.
module pss_score
    import pss_pkg::*;
(
    input  t_score_in i_score,
    output t_out_item o_item
);

    logic       susp;
    logic [2:0] tags;
    logic [4:0] bonus;
    logic [6:0] score;

    always_comb begin
        susp  = i_score.encoded || i_score.flags.sql || i_score.flags.script;
        tags  = (i_score.flags.sled ? 3'd2 : 3'd0) + {2'b00, i_score.encoded}
              + {2'b00, i_score.flags.sql} + {2'b00, i_score.flags.script};
        bonus = {1'b0, tags, 1'b0};
        if (bonus > 5'd20) begin
            bonus = 5'd20;
        end
        score = (i_score.flags.sled ? 7'd40 : 7'd0) + (i_score.net ? 7'd20 : 7'd0)
              + (i_score.files ? 7'd15 : 7'd0) + (susp ? 7'd10 : 7'd0)
              + {2'b00, bonus};
        if (score > SCORE_CAP) begin
            score = SCORE_CAP;
        end
        o_item.injection_seen   = i_score.flags.sled;
        o_item.net_flag         = i_score.net;
        o_item.suspicious_calls = susp;
        o_item.tag_count        = tags;
        o_item.risk_score       = score;
    end

endmodule

### design/payload_signature_scanner.sv
// Top level of the payload signature scanner.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_wdata
//
// One item per cycle unless the input stalls: input register, then matcher,
// counters and score into the result register; a last item's result is
// written there as that item leaves the input register.
// Packet state (history, counters, match flags) updates as items advance.
// Reset (synchronous, active low) empties both registers and the packet state.
// The input side stalls only while a last item waits behind a stalled result.
module payload_signature_scanner
    import pss_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata
);

    localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

    logic [15:0] r_port_a, r_port_b, r_port_c;

    logic     r_in_valid;
    t_in_item r_in;

    logic [WIN_BITS-9:0] r_hist, n_hist;
    logic [CNT_W-1:0]    r_bytes, n_bytes;
    logic [CNT_W-1:0]    r_pairs, n_pairs;
    t_match_flags        r_flags, n_flags;

    logic      r_out_valid;
    t_out_item r_out;

    logic            advance;
    logic [WIN_BITS-1:0] window;
    t_match_flags    hit;
    t_score_in       score_in;
    t_out_item       result;

    assign advance    = r_in_valid && (!r_in.last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign window     = {r_hist, r_in.data_byte};

    pss_match u_match (
        .i_window (window),
        .o_flags  (hit)
    );

    always_comb begin
        n_hist  = r_hist;
        n_bytes = r_bytes;
        n_pairs = r_pairs;
        n_flags = r_flags;
        if (r_in.has_byte) begin
            n_hist = window[WIN_BITS-9:0];
            if (r_bytes != CNT_MAX) begin
                n_bytes = r_bytes + 1'b1;
            end
            // empty history reads zero, so the first byte never pairs
            if (r_hist[7:0] > HIGH_LIMIT && r_in.data_byte > HIGH_LIMIT &&
                r_pairs != CNT_MAX) begin
                n_pairs = r_pairs + 1'b1;
            end
            n_flags = r_flags | hit;
        end
    end

    always_comb begin
        score_in.flags   = n_flags;
        score_in.encoded = n_pairs > (n_bytes >> 2);
        score_in.net     = (r_in.dst_port == r_port_a) || (r_in.dst_port == r_port_b) ||
                           (r_in.dst_port == r_port_c);
        score_in.files   = r_in.files_changed;
    end

    pss_score u_score (
        .i_score (score_in),
        .o_item  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a <= PORT_A_RST;
            r_port_b <= PORT_B_RST;
            r_port_c <= PORT_C_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PORT_A: r_port_a <= i_cfg_wdata;
                CFG_PORT_B: r_port_b <= i_cfg_wdata;
                CFG_PORT_C: r_port_c <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist  <= '0;
            r_bytes <= '0;
            r_pairs <= '0;
            r_flags <= '0;
        end else if (advance) begin
            if (r_in.last_byte) begin
                r_hist  <= '0;
                r_bytes <= '0;
                r_pairs <= '0;
                r_flags <= '0;
            end else begin
                r_hist  <= n_hist;
                r_bytes <= n_bytes;
                r_pairs <= n_pairs;
                r_flags <= n_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last_byte) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### design/pss_checker.sv
// Port-level checker for the payload signature scanner, bound to the top level.
module pss_checker
    import pss_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // input only backs up behind a result that is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed or dropped");

    a_sled_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.injection_seen) |->
        (o_out_item.tag_count >= 3'd2 && o_out_item.risk_score >= 7'd44))
        else $error("sled result without its tags or score");

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.tag_count <= 3'd5 &&
                         o_out_item.risk_score <= SCORE_CAP &&
                         (!o_out_item.net_flag || o_out_item.risk_score >= 7'd20)))
        else $error("result fields out of range");

endmodule

bind payload_signature_scanner pss_checker u_pss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

### test/payload_signature_scanner_checker.sv
// Checker for the payload signature scanner: predicts each packet verdict and compares results.
module payload_signature_scanner_checker
    import pss_pkg::*;
#(
    parameter int unsigned MAX_BYTES = MAX_PACKET_BYTES_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   hist [HIST_DEPTH];
    int unsigned  hist_fill;
    int unsigned  byte_cnt;
    int unsigned  pair_cnt;
    t_match_flags seen;
    logic [15:0]  watch_port [3];
    t_out_item    verdict_q [$];
    int unsigned  fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fail_total++;
    endtask

    function automatic void clear_packet();
        foreach (hist[k]) hist[k] = 8'h00;
        hist_fill = 0;
        byte_cnt  = 0;
        pair_cnt  = 0;
        seen      = '0;
    endfunction

    // Signature ends on the newest byte; it needs len valid bytes in the window
    function automatic bit tail_hit(input logic [WIN_BITS-1:0] win, input int unsigned avail,
                                    input logic [WIN_BITS-1:0] sig, input int unsigned len);
        logic [WIN_BITS-1:0] mask;
        mask = '1;
        if (len * 8 < WIN_BITS)
            mask = ~({WIN_BITS{1'b1}} << (len * 8));
        return (len <= avail) && ((win & mask) == sig);
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic [WIN_BITS-1:0] win;
        int unsigned         avail;
        win = '0;
        win[7:0] = b;
        for (int k = 0; k < HIST_DEPTH; k++)
            win[8*(k+1) +: 8] = hist[k];
        avail = hist_fill + 1;

        if (hist_fill > 0 && hist[0] > HIGH_LIMIT && b > HIGH_LIMIT && pair_cnt < MAX_BYTES)
            pair_cnt++;
        if (byte_cnt < MAX_BYTES)
            byte_cnt++;

        if (tail_hit(win, avail, PAT_SLED, 3))
            seen.sled = 1'b1;
        if (tail_hit(win, avail, PAT_SQL0, 11) || tail_hit(win, avail, PAT_SQL1, 12) ||
            tail_hit(win, avail, PAT_SQL2, 10))
            seen.sql = 1'b1;
        if (tail_hit(win, avail, PAT_JS0, 8) || tail_hit(win, avail, PAT_JS1, 11))
            seen.script = 1'b1;

        for (int k = HIST_DEPTH - 1; k > 0; k--)
            hist[k] = hist[k-1];
        hist[0] = b;
        if (hist_fill < HIST_DEPTH)
            hist_fill++;
    endfunction

    function automatic t_out_item score_packet(input logic [15:0] port, input logic files);
        t_out_item   v;
        logic        encoded, net, susp;
        int unsigned tags, bonus, score;
        encoded = pair_cnt > (byte_cnt / 4);
        net  = (port == watch_port[0]) || (port == watch_port[1]) || (port == watch_port[2]);
        susp = encoded || seen.sql || seen.script;
        tags = (seen.sled ? 2 : 0) + (encoded ? 1 : 0) + (seen.sql ? 1 : 0)
             + (seen.script ? 1 : 0);
        bonus = (tags * 2 > 20) ? 20 : tags * 2;
        score = (seen.sled ? 40 : 0) + (net ? 20 : 0) + (files ? 15 : 0)
              + (susp ? 10 : 0) + bonus;
        if (score > SCORE_CAP)
            score = SCORE_CAP;
        v.injection_seen   = seen.sled;
        v.net_flag         = net;
        v.suspicious_calls = susp;
        v.tag_count        = 3'(tags);
        v.risk_score       = 7'(score);
        return v;
    endfunction

    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            clear_packet();
            watch_port[0] = PORT_A_RST;
            watch_port[1] = PORT_B_RST;
            watch_port[2] = PORT_C_RST;
            verdict_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with no packet pending, score",
                                    i_out_item.risk_score, 0);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_out_item.injection_seen !== want.injection_seen)
                        report_mismatch("injection_seen", i_out_item.injection_seen,
                                        want.injection_seen);
                    if (i_out_item.net_flag !== want.net_flag)
                        report_mismatch("net_flag", i_out_item.net_flag, want.net_flag);
                    if (i_out_item.suspicious_calls !== want.suspicious_calls)
                        report_mismatch("suspicious_calls", i_out_item.suspicious_calls,
                                        want.suspicious_calls);
                    if (i_out_item.tag_count !== want.tag_count)
                        report_mismatch("tag_count", i_out_item.tag_count, want.tag_count);
                    if (i_out_item.risk_score !== want.risk_score)
                        report_mismatch("risk_score", i_out_item.risk_score,
                                        want.risk_score);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PORT_A: watch_port[0] = i_cfg_wdata;
                    CFG_PORT_B: watch_port[1] = i_cfg_wdata;
                    CFG_PORT_C: watch_port[2] = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.has_byte)
                    absorb_byte(i_in_item.data_byte);
                if (i_in_item.last_byte) begin
                    verdict_q.insert(verdict_q.size(),
                                     score_packet(i_in_item.dst_port,
                                                  i_in_item.files_changed));
                    clear_packet();
                end
            end
            o_pending <= verdict_q.size();
        end
    end

endmodule

### test/payload_signature_scanner_tb.sv
// Testbench top for the payload signature scanner: clock, reset, stimulus and verdict.
module payload_signature_scanner_tb
    import pss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Small packet limit so the saturating counters are reachable
    localparam int unsigned PKT_LIMIT   = 64;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned PHASE_ITEMS = 290;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_PORT_A;
    logic [15:0]          cfg_wdata = '0;

    logic                 hold_go   = 1'b0;
    int unsigned          hold_left = 0;
    int unsigned          stall_pct = 0;
    int unsigned          idle_pct  = 0;
    int unsigned          items_sent = 0;
    logic [15:0]          port_set [3];
    int unsigned          fail_count;
    int unsigned          pending;

    payload_signature_scanner #(
        .MAX_PACKET_BYTES (PKT_LIMIT)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    payload_signature_scanner_checker #(
        .MAX_BYTES (PKT_LIMIT)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("payload_signature_scanner_tb NOT OK");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when asked
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_go) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_in_item mk_item(input logic [7:0] b, input logic has, input logic last,
                                         input logic [15:0] port, input logic files);
        t_in_item it;
        it.data_byte     = b;
        it.has_byte      = has;
        it.last_byte     = last;
        it.dst_port      = port;
        it.files_changed = files;
        return it;
    endfunction

    function automatic logic [15:0] pick_port();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return port_set[$urandom_range(2)];
        if (r < 55)
            return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // Returns at the edge that took the item; valid stays high until the next call
    task automatic push_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_ports(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_PORT_A;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_idx   <= CFG_PORT_B;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_idx   <= CFG_PORT_C;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_idx   <= CFG_SPARE;
        cfg_wdata <= 16'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        port_set[0] = a;
        port_set[1] = b;
        port_set[2] = c;
    endtask

    // Random payload seeded with whole, cut and near-miss signatures
    task automatic send_packet(input int unsigned target, input bit hot);
        logic [7:0]          body [$];
        logic [WIN_BITS-1:0] pat;
        int unsigned         r, n, cut, at;
        bit                  tail_only;
        while (body.size() < target) begin
            r = $urandom_range(99);
            if (hot) begin
                body.insert(body.size(), 8'($urandom_range(128, 255)));
            end else if (r < 40) begin
                body.insert(body.size(), 8'($urandom));
            end else if (r < 55) begin
                body.insert(body.size(), 8'($urandom_range(128, 255)));
            end else if (r < 65) begin
                body.insert(body.size(), 8'h90);
            end else begin
                case ($urandom_range(5))
                    0: begin pat = PAT_SLED; n = 3; end
                    1: begin pat = PAT_SQL0; n = 11; end
                    2: begin pat = PAT_SQL1; n = 12; end
                    3: begin pat = PAT_SQL2; n = 10; end
                    4: begin pat = PAT_JS0; n = 8; end
                    default: begin pat = PAT_JS1; n = 11; end
                endcase
                cut = ($urandom_range(99) < 70) ? n : $urandom_range(1, n);
                at  = body.size();
                for (int k = 0; k < cut; k++)
                    body.insert(body.size(), pat[8*(n-1-k) +: 8]);
                if ($urandom_range(9) == 0)
                    body[at] = body[at] ^ 8'h20;
            end
        end

        tail_only = (body.size() == 0) || ($urandom_range(99) < 12);
        foreach (body[i]) begin
            if ($urandom_range(99) < 4)
                push_item(mk_item(8'($urandom), 1'b0, 1'b0, 16'($urandom), 1'($urandom)));
            push_item(mk_item(body[i], 1'b1, !tail_only && i == body.size() - 1,
                              pick_port(), 1'($urandom)));
            items_sent++;
        end
        if (tail_only) begin
            push_item(mk_item(8'($urandom), 1'b0, 1'b1, pick_port(), 1'($urandom)));
            items_sent++;
        end
    endtask

    initial begin : main
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        port_set[0] = PORT_A_RST;
        port_set[1] = PORT_B_RST;
        port_set[2] = PORT_C_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty packet on a reset-value port
        push_item(mk_item(8'h00, 1'b0, 1'b1, PORT_A_RST, 1'b0));
        // Sled with stray items in between, which must not break it
        push_item(mk_item(8'h5A, 1'b0, 1'b0, 16'hFFFF, 1'b1));
        push_item(mk_item(8'h90, 1'b1, 1'b0, 16'h0000, 1'b0));
        push_item(mk_item(8'h90, 1'b1, 1'b0, 16'h0000, 1'b0));
        push_item(mk_item(8'hFF, 1'b0, 1'b0, 16'h0000, 1'b1));
        push_item(mk_item(8'h90, 1'b1, 1'b1, 16'hFFFF, 1'b1));
        // Sled split over two packets never matches
        push_item(mk_item(8'h90, 1'b1, 1'b0, 16'h0000, 1'b0));
        push_item(mk_item(8'h90, 1'b1, 1'b1, PORT_B_RST, 1'b0));
        push_item(mk_item(8'h90, 1'b1, 1'b1, 16'h0000, 1'b0));
        for (int k = 0; k < 8; k++)
            push_item(mk_item(PAT_JS0[8*(7-k) +: 8], 1'b1, k == 7, PORT_C_RST, 1'b0));
        // High pair, then a byte-less last item
        push_item(mk_item(8'hFF, 1'b1, 1'b0, 16'h0000, 1'b0));
        push_item(mk_item(8'hFF, 1'b1, 1'b0, 16'h0000, 1'b0));
        push_item(mk_item(8'hFF, 1'b0, 1'b1, 16'h0000, 1'b1));

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: load_ports(16'h0000, 16'hFFFF, 16'($urandom));
                1: load_ports(16'($urandom), 16'($urandom), 16'($urandom));
                2: load_ports(16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: load_ports(16'($urandom), 16'h0000, 16'h0000);
            endcase
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 68; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 68; end
                default: begin idle_pct = 12; stall_pct <= 12; end
            endcase
            // Oversized packets drive both counters into saturation
            if (ph == 0 || ph == 3)
                send_packet(70, 1'b1);
            while (items_sent < (ph + 1) * PHASE_ITEMS) begin
                if (ph == 0 && !held && items_sent > 120) begin
                    in_valid <= 1'b0;
                    hold_go  <= 1'b1;
                    @(posedge clk);
                    hold_go  <= 1'b0;
                    held = 1'b1;
                end
                if (ph == 2 && !paused && items_sent > 2 * PHASE_ITEMS + 150) begin
                    drain();
                    paused = 1'b1;
                end
                send_packet(($urandom_range(24) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 14),
                            $urandom_range(9) == 0);
            end
        end

        stall_pct <= 0;
        drain();
        if (fail_count == 0)
            $display("payload_signature_scanner_tb OK");
        else
            $display("payload_signature_scanner_tb NOT OK");
        $finish;
    end

endmodule

### payload_signature_scanner.f
design/pss_pkg.sv
design/pss_match.sv
design/pss_score.sv
design/payload_signature_scanner.sv
design/pss_checker.sv
test/payload_signature_scanner_checker.sv
test/payload_signature_scanner_tb.sv
